/* src/sida_pkg.sv */
// Package for the signed integer to decimal ASCII formatter.
// Shared widths, character codes, register indexes and the converter-to-emitter item.
// No dependencies.
`default_nettype none

package sida_pkg;

    localparam int VALUE_W     = 32;
    localparam int BIT_CNT_W   = $clog2(VALUE_W);
    localparam int NUM_BCD     = 10;
    localparam int BCD_W       = NUM_BCD * 4;
    localparam int NDIG_W      = $clog2(NUM_BCD + 1);
    localparam int MIN_DIG_W   = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CHAR_W      = 8;

    localparam logic [MIN_DIG_W-1:0] MAX_DIGITS = MIN_DIG_W'(32);

    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DIGITS     = 2'd0,
        CFG_FORCE_PLUS     = 2'd1,
        CFG_BLANK_POSITIVE = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic             neg;
        logic             zero;
    } t_conv_res;

    typedef struct packed {
        logic [MIN_DIG_W-1:0] min_digits;
        logic                 force_plus;
        logic                 blank_positive;
    } t_fmt_cfg;

    function automatic logic bcd_ok(input logic [BCD_W-1:0] b);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < NUM_BCD; i++) begin
            if (b[i*4 +: 4] > 4'd9) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

/* src/sida_dabble.sv */
// Bit-serial binary to BCD converter (shift and add three), one bit per cycle.
// Depends on sida_pkg.
`default_nettype none

module sida_dabble (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [sida_pkg::VALUE_W-1:0]    i_value,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output sida_pkg::t_conv_res                  o_res
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SHIFT = 3'b010,
        ST_DONE  = 3'b100
    } t_state;

    t_state                             r_state, n_state;
    logic [sida_pkg::BIT_CNT_W-1:0]     r_cnt, n_cnt;
    logic [sida_pkg::VALUE_W-1:0]       r_mag, n_mag;
    logic [sida_pkg::BCD_W-1:0]         r_bcd, n_bcd;
    logic                               r_neg, n_neg;
    logic                               r_zero, n_zero;
    logic [sida_pkg::BCD_W-1:0]         adj;

    always_comb begin
        for (int i = 0; i < sida_pkg::NUM_BCD; i++) begin
            adj[i*4 +: 4] = (r_bcd[i*4 +: 4] >= 4'd5) ? r_bcd[i*4 +: 4] + 4'd3
                                                      : r_bcd[i*4 +: 4];
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_mag   = r_mag;
        n_bcd   = r_bcd;
        n_neg   = r_neg;
        n_zero  = r_zero;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_neg   = i_value[sida_pkg::VALUE_W-1];
                    n_zero  = (i_value == '0);
                    n_mag   = i_value[sida_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;
                    n_bcd   = '0;
                    n_cnt   = '0;
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: begin
                n_bcd = {adj[sida_pkg::BCD_W-2:0], r_mag[sida_pkg::VALUE_W-1]};
                n_mag = {r_mag[sida_pkg::VALUE_W-2:0], 1'b0};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_cnt  <= n_cnt;
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    assign o_ready    = (r_state == ST_IDLE);
    assign o_valid    = (r_state == ST_DONE);
    assign o_res.bcd  = r_bcd;
    assign o_res.neg  = r_neg;
    assign o_res.zero = r_zero;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_SHIFT && r_cnt == '0))
        else $error("conversion did not start on accept");

    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> sida_pkg::bcd_ok(r_bcd))
        else $error("BCD digit out of range");

    a_done_from_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_SHIFT && r_cnt == '1))
        else $error("result before all bits shifted");

endmodule

`default_nettype wire

/* src/sida_emit.sv */
// Character emitter: sign, leading zeros, then BCD digits, through an output register.
// Depends on sida_pkg.
`default_nettype none

module sida_emit (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire sida_pkg::t_conv_res             i_res,
    input  wire sida_pkg::t_fmt_cfg              i_cfg,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [sida_pkg::CHAR_W-1:0]          o_char,
    output logic                                 o_last
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SIGN  = 4'b0010,
        ST_PAD   = 4'b0100,
        ST_DIGIT = 4'b1000
    } t_state;

    t_state                             r_state, n_state;
    logic [sida_pkg::BCD_W-1:0]         r_bcd, n_bcd;
    logic [sida_pkg::NDIG_W-1:0]        r_ndig, n_ndig;
    logic [sida_pkg::MIN_DIG_W-1:0]     r_pad, n_pad;
    logic [sida_pkg::CHAR_W-1:0]        r_sign, n_sign;
    logic                               r_valid, n_valid;
    logic [sida_pkg::CHAR_W-1:0]        r_char, n_char;
    logic                               r_last, n_last;

    logic [sida_pkg::NDIG_W-1:0]        ld_ndig;
    logic [sida_pkg::MIN_DIG_W-1:0]     ld_width;
    logic [sida_pkg::MIN_DIG_W-1:0]     ld_pad;
    logic                               ld_has_sign;
    logic [sida_pkg::CHAR_W-1:0]        ld_sign;
    logic [3:0]                         cur_digit;
    logic                               adv;

    always_comb begin
        ld_ndig = sida_pkg::NDIG_W'(1);
        for (int i = 0; i < sida_pkg::NUM_BCD; i++) begin
            if (i_res.bcd[i*4 +: 4] != 4'd0) begin
                ld_ndig = sida_pkg::NDIG_W'(i + 1);
            end
        end
        ld_width = (i_cfg.min_digits > sida_pkg::MAX_DIGITS) ? sida_pkg::MAX_DIGITS
                                                            : i_cfg.min_digits;
        if (i_res.zero) begin
            ld_pad = '0;
        end else if (ld_width > sida_pkg::MIN_DIG_W'(ld_ndig)) begin
            ld_pad = ld_width - sida_pkg::MIN_DIG_W'(ld_ndig);
        end else begin
            ld_pad = '0;
        end
        ld_has_sign = 1'b0;
        ld_sign     = sida_pkg::CH_SPACE;
        priority if (i_res.zero) begin
            ld_has_sign = 1'b0;
        end else if (i_res.neg) begin
            ld_has_sign = 1'b1;
            ld_sign     = sida_pkg::CH_MINUS;
        end else if (i_cfg.force_plus) begin
            ld_has_sign = 1'b1;
            ld_sign     = sida_pkg::CH_PLUS;
        end else if (i_cfg.blank_positive) begin
            ld_has_sign = 1'b1;
            ld_sign     = sida_pkg::CH_SPACE;
        end else begin
            ld_has_sign = 1'b0;
        end
    end

    always_comb begin
        cur_digit = 4'd0;
        for (int i = 0; i < sida_pkg::NUM_BCD; i++) begin
            if (r_ndig == sida_pkg::NDIG_W'(i + 1)) begin
                cur_digit = r_bcd[i*4 +: 4];
            end
        end
    end

    assign adv = (!r_valid || i_ready) && (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_bcd   = r_bcd;
        n_ndig  = r_ndig;
        n_pad   = r_pad;
        n_sign  = r_sign;
        n_valid = r_valid;
        n_char  = r_char;
        n_last  = r_last;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_bcd  = i_res.bcd;
                    n_ndig = ld_ndig;
                    n_pad  = ld_pad;
                    n_sign = ld_sign;
                    if (ld_has_sign) begin
                        n_state = ST_SIGN;
                    end else if (ld_pad != '0) begin
                        n_state = ST_PAD;
                    end else begin
                        n_state = ST_DIGIT;
                    end
                end
            end
            ST_SIGN: begin
                if (adv) begin
                    n_valid = 1'b1;
                    n_char  = r_sign;
                    n_last  = 1'b0;
                    n_state = (r_pad != '0) ? ST_PAD : ST_DIGIT;
                end
            end
            ST_PAD: begin
                if (adv) begin
                    n_valid = 1'b1;
                    n_char  = sida_pkg::CH_ZERO;
                    n_last  = 1'b0;
                    n_pad   = r_pad - 1'b1;
                    if (r_pad == sida_pkg::MIN_DIG_W'(1)) begin
                        n_state = ST_DIGIT;
                    end
                end
            end
            ST_DIGIT: begin
                if (adv) begin
                    n_valid = 1'b1;
                    n_char  = sida_pkg::CH_ZERO + {4'd0, cur_digit};
                    n_last  = (r_ndig == sida_pkg::NDIG_W'(1));
                    n_ndig  = r_ndig - 1'b1;
                    if (r_ndig == sida_pkg::NDIG_W'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_bcd  <= n_bcd;
        r_ndig <= n_ndig;
        r_pad  <= n_pad;
        r_sign <= n_sign;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

    a_digit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIGIT) |-> (r_ndig != '0 && r_ndig <= sida_pkg::NDIG_W'(sida_pkg::NUM_BCD)))
        else $error("digit count out of range while emitting");

    a_pad_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_PAD) |-> (r_pad != '0 && r_pad <= sida_pkg::MAX_DIGITS))
        else $error("pad count out of range");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_state == ST_DIGIT && r_ndig == sida_pkg::NDIG_W'(1)) |=>
        (r_state == ST_IDLE && r_valid && r_last))
        else $error("final digit did not end the number");

endmodule

`default_nettype wire

/* src/signed_int_to_decimal_ascii_top.sv */
// Top level of the signed integer to decimal ASCII formatter: stream ports,
// configuration registers, converter and emitter. Depends on sida_pkg, sida_dabble, sida_emit.
//
// Takes one signed 32-bit item on the slave stream and sends its decimal text on the
// master stream, one ASCII character per item, most significant first, tlast on the
// final character. Conversion is bit serial: accept, shift-and-add-three over all 32
// bits, then hand-over to the emitter. Characters then leave from the emitter's output
// register at one per cycle while the master stream is ready, and the next input item
// is meanwhile already converting. Zero always gives the single character '0'. Negative
// values always show '-'; min_digits (saturated to 32) pads with leading zeros;
// force_plus and blank_positive prefix positive values. Write the configuration
// only while the block is idle.
`default_nettype none

module signed_int_to_decimal_ascii_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [sida_pkg::VALUE_W-1:0]       s_axis_tdata,   // [31:0] value
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [sida_pkg::CHAR_W-1:0]             m_axis_tdata,   // [7:0] char_code
    output logic                                    m_axis_tlast,   // last_char
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [sida_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sida_pkg::MIN_DIG_W-1:0]     i_cfg_data
);

    logic [sida_pkg::MIN_DIG_W-1:0] r_min_digits;
    logic                           r_force_plus;
    logic                           r_blank_pos;
    sida_pkg::t_fmt_cfg             fmt_cfg;
    sida_pkg::t_conv_res            conv_res;
    logic                           conv_valid;
    logic                           emit_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_digits <= '0;
            r_force_plus <= 1'b0;
            r_blank_pos  <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sida_pkg::CFG_MIN_DIGITS:     r_min_digits <= i_cfg_data;
                sida_pkg::CFG_FORCE_PLUS:     r_force_plus <= i_cfg_data[0];
                sida_pkg::CFG_BLANK_POSITIVE: r_blank_pos  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign fmt_cfg.min_digits     = r_min_digits;
    assign fmt_cfg.force_plus     = r_force_plus;
    assign fmt_cfg.blank_positive = r_blank_pos;

    sida_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_value (s_axis_tdata),
        .o_valid (conv_valid),
        .i_ready (emit_ready),
        .o_res   (conv_res)
    );

    sida_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (conv_valid),
        .o_ready (emit_ready),
        .i_res   (conv_res),
        .i_cfg   (fmt_cfg),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire
